### hw/rtl/acli_pkg.sv
// Shared types, character codes and digit helpers of the command line interpreter.
package acli_pkg;

    // Default depth of the line store.
    localparam int LINE_BYTES_DEF = 16;

    // Only the first positions of a line take part in a command.
    localparam int CMD_SPAN = 10;

    // Longest reply and the width of a beat count.
    localparam int REPLY_MAX = 10;
    localparam int LEN_W     = 4;

    // Reply lengths in beats.
    localparam logic [LEN_W-1:0] LEN_SPEED = LEN_W'(6);
    localparam logic [LEN_W-1:0] LEN_FLAGS = LEN_W'(7);
    localparam logic [LEN_W-1:0] LEN_TIME  = LEN_W'(10);
    localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);

    // Character codes.
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_W    = 8'h57;

    // Commands found at the start of a finished line.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_SET_SPEED,
        CMD_SET_FLAGS,
        CMD_SET_CLOCK,
        CMD_SET_WAKE,
        CMD_SET_SLEEP,
        CMD_GET_SPEED,
        CMD_GET_FLAGS,
        CMD_GET_CLOCK,
        CMD_GET_WAKE,
        CMD_GET_SLEEP
    } t_cmd;

    // Decoded line, handed from the line buffer to the executer.
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  speed;
        logic        flag_sleep;
        logic        flag_wake;
        logic [24:0] tval;
    } t_cmd_info;

    // Everything the output stage needs for one input byte.
    typedef struct packed {
        logic [REPLY_MAX-1:0][7:0] data;
        logic [LEN_W-1:0]          len;
        logic                      reply;
        logic [7:0]                speed;
        logic                      sleep;
        logic                      wake;
    } t_result;

    // Two ASCII decimal digits of (v / 10) % 10 and v % 10, for v below 128.
    function automatic logic [15:0] f_dec2(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        ones = v - 7'(tens) * 7'd10;
        if (tens >= 4'd10) begin
            tens = tens - 4'd10;
        end
        return {CH_ZERO | {4'd0, tens}, CH_ZERO | {4'd0, ones[3:0]}};
    endfunction

    // One ASCII digit of v % 10.
    function automatic logic [7:0] f_dec1(input logic [3:0] v);
        logic [3:0] d;
        d = (v >= 4'd10) ? v - 4'd10 : v;
        return CH_ZERO | {4'd0, d};
    endfunction

endpackage

### hw/rtl/acli_line.sv
// Line store with its fill count and the decoder of the command at the line start.
module acli_line #(
    parameter int LINE_BYTES = acli_pkg::LINE_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    output acli_pkg::t_cmd_info  o_info
);
    import acli_pkg::*;

    localparam int LW = $clog2(LINE_BYTES + 1);
    localparam int IW = $clog2(LINE_BYTES);

    logic [7:0]    r_line [LINE_BYTES];
    logic [LW-1:0] r_len;

    logic                         is_nl;
    logic                         has_room;
    logic [7:0]                   ch   [CMD_SPAN];
    logic [CMD_SPAN-1:0]          dig;
    logic [CMD_SPAN-1:0][3:0]     num;
    logic [9:0]                   speed_sum;
    logic [6:0]                   hour;
    logic [6:0]                   minute;
    logic [6:0]                   second;
    logic                         flags_ok;
    logic                         digits3;
    logic                         digits7;

    assign is_nl    = (i_byte == CH_NL);
    assign has_room = (r_len < LW'(LINE_BYTES));

    // Fill count: a newline empties the line, extra bytes past the end are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_step) begin
            if (is_nl) begin
                r_len <= '0;
            end else if (has_room) begin
                r_len <= r_len + 1'b1;
            end
        end
    end

    // Byte storage; entries at or past the fill count are never read as data.
    always_ff @(posedge i_clk) begin
        if (i_step && !is_nl && has_room) begin
            r_line[r_len[IW-1:0]] <= i_byte;
        end
    end

    // Positions at or past the fill count read as zero.
    always_comb begin
        for (int p = 0; p < CMD_SPAN; p++) begin
            ch[p]  = (LW'(p) < r_len) ? r_line[p] : 8'd0;
            dig[p] = (ch[p] >= CH_ZERO) && (ch[p] <= CH_NINE);
            num[p] = ch[p][3:0];
        end
    end

    assign digits3   = &dig[4:2];
    assign digits7   = &dig[8:2];
    assign flags_ok  = (ch[2] == CH_P) && (ch[3] == CH_ZERO || ch[3] == CH_ONE) &&
                       (ch[4] == CH_W) && (ch[5] == CH_ZERO || ch[5] == CH_ONE);
    assign speed_sum = 10'(num[2]) * 10'd100 + 10'(num[3]) * 10'd10 + 10'(num[4]);
    assign hour      = 7'(num[2]) * 7'd10 + 7'(num[3]);
    assign minute    = 7'(num[4]) * 7'd10 + 7'(num[5]);
    assign second    = 7'(num[6]) * 7'd10 + 7'(num[7]);

    // Command decode on a newline.
    always_comb begin
        o_info            = '0;
        o_info.cmd        = CMD_NONE;
        o_info.speed      = speed_sum[7:0];
        o_info.flag_sleep = ch[3][0];
        o_info.flag_wake  = ch[5][0];
        o_info.tval       = {hour, minute, second, num[8]};
        if (is_nl && ch[0] == CH_S) begin
            unique case (ch[1])
                CH_D: o_info.cmd = digits3  ? CMD_SET_SPEED : CMD_NONE;
                CH_F: o_info.cmd = flags_ok ? CMD_SET_FLAGS : CMD_NONE;
                CH_T: o_info.cmd = digits7  ? CMD_SET_CLOCK : CMD_NONE;
                CH_W: o_info.cmd = digits7  ? CMD_SET_WAKE  : CMD_NONE;
                CH_P: o_info.cmd = digits7  ? CMD_SET_SLEEP : CMD_NONE;
                default: o_info.cmd = CMD_NONE;
            endcase
        end else if (is_nl && ch[0] == CH_G) begin
            unique case (ch[1])
                CH_D: o_info.cmd = CMD_GET_SPEED;
                CH_F: o_info.cmd = CMD_GET_FLAGS;
                CH_T: o_info.cmd = CMD_GET_CLOCK;
                CH_W: o_info.cmd = CMD_GET_WAKE;
                CH_P: o_info.cmd = CMD_GET_SLEEP;
                default: o_info.cmd = CMD_NONE;
            endcase
        end
    end

    // The fill count never passes the store depth.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(LINE_BYTES))
        else $error("line fill count beyond store depth");

endmodule

### hw/rtl/acli_exec.sv
// Settings and time registers, command execution and reply formatting.
module acli_exec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  acli_pkg::t_cmd_info i_info,
    output acli_pkg::t_result   o_result
);
    import acli_pkg::*;

    logic [24:0] r_clock;
    logic [24:0] r_wake_time;
    logic [24:0] r_sleep_time;
    logic [7:0]  r_speed;
    logic        r_sleep;
    logic        r_wake;

    logic [24:0] n_clock;
    logic [24:0] n_wake_time;
    logic [24:0] n_sleep_time;
    logic [7:0]  n_speed;
    logic        n_sleep;
    logic        n_wake;

    logic [REPLY_MAX-1:0][7:0] data;
    logic [LEN_W-1:0]          len;
    logic [6:0]                speed_rem;
    logic [7:0]                speed_hund;
    logic [15:0]               speed_dec;

    // Reply text for a time value: letter, hhmmss, weekday, newline, return.
    function automatic logic [REPLY_MAX-1:0][7:0] f_time_reply(
        input logic [7:0]  letter,
        input logic [24:0] t
    );
        logic [REPLY_MAX-1:0][7:0] d;
        logic [15:0]               hh;
        logic [15:0]               mm;
        logic [15:0]               ss;
        hh   = f_dec2(t[24:18]);
        mm   = f_dec2(t[17:11]);
        ss   = f_dec2(t[10:4]);
        d    = '0;
        d[0] = letter;
        d[1] = hh[15:8];
        d[2] = hh[7:0];
        d[3] = mm[15:8];
        d[4] = mm[7:0];
        d[5] = ss[15:8];
        d[6] = ss[7:0];
        d[7] = f_dec1(t[3:0]);
        d[8] = CH_NL;
        d[9] = CH_CR;
        return d;
    endfunction

    // Next values of the held settings.
    always_comb begin
        n_clock      = r_clock;
        n_wake_time  = r_wake_time;
        n_sleep_time = r_sleep_time;
        n_speed      = r_speed;
        n_sleep      = r_sleep;
        n_wake       = r_wake;
        if (i_step) begin
            unique case (i_info.cmd)
                CMD_SET_SPEED: n_speed = i_info.speed;
                CMD_SET_FLAGS: begin
                    n_sleep = i_info.flag_sleep;
                    n_wake  = i_info.flag_wake;
                end
                CMD_SET_CLOCK: n_clock = i_info.tval;
                CMD_SET_WAKE: begin
                    n_wake_time = i_info.tval;
                    n_wake      = 1'b1;
                end
                CMD_SET_SLEEP: begin
                    n_sleep_time = i_info.tval;
                    n_sleep      = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock      <= '0;
            r_wake_time  <= '0;
            r_sleep_time <= '0;
            r_speed      <= '0;
            r_sleep      <= 1'b0;
            r_wake       <= 1'b0;
        end else begin
            r_clock      <= n_clock;
            r_wake_time  <= n_wake_time;
            r_sleep_time <= n_sleep_time;
            r_speed      <= n_speed;
            r_sleep      <= n_sleep;
            r_wake       <= n_wake;
        end
    end

    // Speed split into hundreds by compare and subtract, then two digits.
    always_comb begin
        if (r_speed >= 8'd200) begin
            speed_hund = CH_ZERO + 8'd2;
            speed_rem  = 7'(r_speed - 8'd200);
        end else if (r_speed >= 8'd100) begin
            speed_hund = CH_ONE;
            speed_rem  = 7'(r_speed - 8'd100);
        end else begin
            speed_hund = CH_ZERO;
            speed_rem  = r_speed[6:0];
        end
    end

    assign speed_dec = f_dec2(speed_rem);

    // Reply bytes for get commands.
    always_comb begin
        data = '0;
        len  = '0;
        unique case (i_info.cmd)
            CMD_GET_SPEED: begin
                data[0] = CH_D;
                data[1] = speed_hund;
                data[2] = speed_dec[15:8];
                data[3] = speed_dec[7:0];
                data[4] = CH_NL;
                data[5] = CH_CR;
                len     = LEN_SPEED;
            end
            CMD_GET_FLAGS: begin
                data[0] = CH_F;
                data[1] = CH_P;
                data[2] = CH_ZERO | {7'd0, r_sleep};
                data[3] = CH_W;
                data[4] = CH_ZERO | {7'd0, r_wake};
                data[5] = CH_NL;
                data[6] = CH_CR;
                len     = LEN_FLAGS;
            end
            CMD_GET_CLOCK: begin
                data = f_time_reply(CH_T, r_clock);
                len  = LEN_TIME;
            end
            CMD_GET_WAKE: begin
                data = f_time_reply(CH_W, r_wake_time);
                len  = LEN_TIME;
            end
            CMD_GET_SLEEP: begin
                data = f_time_reply(CH_P, r_sleep_time);
                len  = LEN_TIME;
            end
            default: begin
            end
        endcase
    end

    // A byte without reply still gives one beat; status shows values after the byte.
    always_comb begin
        o_result.data  = data;
        o_result.reply = (len != '0);
        o_result.len   = (len != '0) ? len : LEN_ONE;
        o_result.speed = n_speed;
        o_result.sleep = n_sleep;
        o_result.wake  = n_wake;
    end

endmodule

### hw/rtl/acli_tx.sv
// Output register that sends a result one beat at a time from a shift register.
module acli_tx (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  acli_pkg::t_result i_result,
    output logic              o_can_load,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_tx_byte,
    output logic              o_reply_valid,
    output logic              o_last,
    output logic [7:0]        o_speed_setpoint,
    output logic              o_sleep_enable,
    output logic              o_wake_enable
);
    import acli_pkg::*;

    logic                      r_valid;
    logic [LEN_W-1:0]          r_left;
    logic [REPLY_MAX-1:0][7:0] r_buf;
    logic                      r_reply;
    logic [7:0]                r_speed;
    logic                      r_sleep;
    logic                      r_wake;

    logic beat;
    logic is_last;

    assign is_last    = (r_left == LEN_ONE);
    assign beat       = r_valid && i_out_ready;
    assign o_can_load = !r_valid || (beat && is_last);

    // Beat count and valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_left  <= i_result.len;
        end else if (beat) begin
            r_valid <= !is_last;
            r_left  <= r_left - 1'b1;
        end
    end

    // Payload: load a whole result, shift one byte out per beat.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf   <= i_result.data;
            r_reply <= i_result.reply;
            r_speed <= i_result.speed;
            r_sleep <= i_result.sleep;
            r_wake  <= i_result.wake;
        end else if (beat) begin
            r_buf <= {8'd0, r_buf[REPLY_MAX-1:1]};
        end
    end

    assign o_out_valid      = r_valid;
    assign o_tx_byte        = r_buf[0];
    assign o_reply_valid    = r_reply;
    assign o_last           = is_last;
    assign o_speed_setpoint = r_speed;
    assign o_sleep_enable   = r_sleep;
    assign o_wake_enable    = r_wake;

    // A held result always has between one and the longest reply beats left.
    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_left != '0 && r_left <= LEN_W'(REPLY_MAX)))
        else $error("beat count out of range");

    // A beat that is not the last keeps the same result in the register.
    a_keep_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat && !is_last) |=> (r_valid && $stable(r_reply) && $stable(r_speed)))
        else $error("result dropped before its last beat");

    // A result without reply text is a single beat.
    a_no_reply_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_reply) |-> (is_last && r_buf[0] == 8'd0))
        else $error("non-reply result longer than one beat");

endmodule

### hw/rtl/ascii_command_line_interpreter.sv
// Top level of the ASCII command line interpreter.
// A byte accepted into the input register is loaded into the output register once that
// register can take a result; throughput is one byte per cycle while each byte gives a
// single beat and the output is ready. A get command's newline holds the output shift
// register for 6, 7 or 10 beats, one reply byte per beat.
// Reset is synchronous, active low: line fill count, times, speed and flags clear to zero.
module ascii_command_line_interpreter #(
    parameter int LINE_BYTES = acli_pkg::LINE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_tx_byte,
    output logic       o_reply_valid,
    output logic       o_last,
    output logic [7:0] o_speed_setpoint,
    output logic       o_sleep_enable,
    output logic       o_wake_enable
);
    import acli_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic      can_load;
    logic      step;
    t_cmd_info info;
    t_result   result;

    assign step       = r_in_valid && can_load;
    assign o_rx_ready = !r_in_valid || can_load;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && o_rx_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    acli_line #(
        .LINE_BYTES(LINE_BYTES)
    ) u_line (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_byte (r_in_byte),
        .o_info (info)
    );

    acli_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_info  (info),
        .o_result(result)
    );

    acli_tx u_tx (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (step),
        .i_result        (result),
        .o_can_load      (can_load),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_tx_byte       (o_tx_byte),
        .o_reply_valid   (o_reply_valid),
        .o_last          (o_last),
        .o_speed_setpoint(o_speed_setpoint),
        .o_sleep_enable  (o_sleep_enable),
        .o_wake_enable   (o_wake_enable)
    );

endmodule
